### src/stream_first_match_replace_top_macros.svh
// stream_first_match_replace_top_macros.svh: assertion macros for the search/replace block
// expects signals clk and arst_n in the module that uses them
`ifndef STREAM_FIRST_MATCH_REPLACE_TOP_MACROS_SVH
`define STREAM_FIRST_MATCH_REPLACE_TOP_MACROS_SVH

// property that holds at every clock edge outside reset
`define SFMR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition that must hold in the cycle after a trigger
`define SFMR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

### src/sfmr_pkg.sv
// sfmr_pkg.sv: shared types and register codes for the first-match search/replace block
// no dependencies
package sfmr_pkg;

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_PATTERN_LENGTH     = 2'd0,
		CFG_PATTERN_BYTES      = 2'd1,
		CFG_REPLACEMENT_LENGTH = 2'd2,
		CFG_REPLACEMENT_BYTES  = 2'd3
	} cfg_idx_t;

	// one result word
	typedef struct packed {
		logic [7:0] out_byte;
		logic       has_byte;
		logic       run_last;
		logic       line_end;
	} res_t;

	// control into one window cell
	typedef struct packed {
		logic use_store;
		logic active;
		logic load;
	} win_ctl_t;

	// control into one output queue cell
	typedef struct packed {
		logic load;
		logic load_below;
		logic shift;
	} oq_ctl_t;

endpackage

### src/stream_first_match_replace_top.sv
// stream_first_match_replace_top.sv: per-line first-match search and replace on a byte stream
// depends on sfmr_pkg, sfmr_win_cell, sfmr_out_cell, stream_first_match_replace_top_macros.svh
//
// Usage:
//   Input words carry one text byte on s_tdata[7:0]; s_tlast marks the final byte of a line.
//   Output words carry out_byte on m_tdata[7:0], has_byte on m_tuser[0], run_last on
//   m_tuser[1] and line_end on m_tlast. A word with has_byte low is a bare line-end marker.
//   Within each line the leftmost match of the pattern is replaced; the rest passes through.
//   The window is a row of byte cells with one comparator each, so a byte is tested and
//   the results are formed in the cycle it is accepted.
//   The results of an accepted byte are registered in the output queue before they show.
//   Throughput: one byte per cycle while each byte yields at most one word and m_tready
//   stays high. A byte may yield several words (replacement, line flush), and
//   s_tready is high while the output queue holds at most one word.
//   The output queue (one more entry than the largest burst) decouples both sides: when
//   the receiver stalls, s_tready drops once two or more words wait, until they drain.
//   Reset clears the window, the queue and the line state, and sets pattern length 1 with
//   all other registers zero. Configuration is written through cfg_we/cfg_index/cfg_data.
`include "stream_first_match_replace_top_macros.svh"

module stream_first_match_replace_top #(
	parameter int PATTERN_MAX     = 8,
	parameter int REPLACEMENT_MAX = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_byte
	input  logic        s_tlast,   // ends_line
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] out_byte
	output logic [1:0]  m_tuser,   // [0] has_byte, [1] run_last
	output logic        m_tlast    // line_end
);

	localparam int PAT_CAP = (PATTERN_MAX < 8) ? PATTERN_MAX : 8;
	localparam int REP_CAP = (REPLACEMENT_MAX < 8) ? REPLACEMENT_MAX : 8;
	localparam int MAXRES  = (PAT_CAP > REP_CAP) ? PAT_CAP : REP_CAP;
	localparam int QD      = MAXRES + 1;
	localparam int CW      = $clog2(PAT_CAP + 1);
	localparam int RW      = $clog2(REP_CAP + 1);
	localparam int NW      = $clog2(MAXRES + 1);
	localparam int QCW     = $clog2(QD + 1);
	localparam int EXT     = 2 * MAXRES;

	// configuration registers
	logic [3:0]  plen_q;
	logic [63:0] pat_q;
	logic [3:0]  rlen_q;
	logic [63:0] rep_q;

	// line state
	logic [CW-1:0] fill_q;
	logic          replaced_q;

	// output queue state
	logic [QCW-1:0] cnt_q;

	logic [CW-1:0]      plen_e;
	logic [RW-1:0]      rlen_e;
	logic [CW-1:0]      fillp;
	logic [CW-1:0]      pc;
	logic [CW-1:0]      k;
	logic [NW-1:0]      n;
	logic               match;
	logic               push;
	logic               pop;
	logic               base1;
	logic [7:0]         wp   [PAT_CAP];
	logic [7:0]         nxt  [PAT_CAP];
	logic [7:0]         wp_x [EXT];
	logic [PAT_CAP-1:0] eq;
	sfmr_pkg::win_ctl_t win_ctl [PAT_CAP];
	sfmr_pkg::res_t     res  [QD];
	sfmr_pkg::res_t     oq   [QD];
	sfmr_pkg::oq_ctl_t  oq_ctl [QD];

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plen_q <= 4'd1;
			pat_q  <= '0;
			rlen_q <= '0;
			rep_q  <= '0;
		end else if (cfg_we) begin
			unique case (sfmr_pkg::cfg_idx_t'(cfg_index))
				sfmr_pkg::CFG_PATTERN_LENGTH:     plen_q <= cfg_data[3:0];
				sfmr_pkg::CFG_PATTERN_BYTES:      pat_q  <= cfg_data;
				sfmr_pkg::CFG_REPLACEMENT_LENGTH: rlen_q <= cfg_data[3:0];
				sfmr_pkg::CFG_REPLACEMENT_BYTES:  rep_q  <= cfg_data;
			endcase
		end
	end

	// effective lengths, clamped to the supported range
	always_comb begin
		if (plen_q == '0) begin
			plen_e = CW'(1);
		end else if (32'(plen_q) > PAT_CAP) begin
			plen_e = CW'(PAT_CAP);
		end else begin
			plen_e = CW'(plen_q);
		end
		if (32'(rlen_q) > REP_CAP) begin
			rlen_e = RW'(REP_CAP);
		end else begin
			rlen_e = RW'(rlen_q);
		end
	end

	// handshakes
	assign pop      = m_tvalid && m_tready;
	assign s_tready = cnt_q <= QCW'(1);
	assign push     = s_tvalid && s_tready;

	// window cell row
	for (genvar i = 0; i < PAT_CAP; i++) begin : g_win
		assign win_ctl[i].use_store = fill_q > CW'(i);
		assign win_ctl[i].active    = plen_e > CW'(i);
		assign win_ctl[i].load      = push;

		sfmr_win_cell u_cell (
			.clk       (clk),
			.ctl       (win_ctl[i]),
			.in_byte   (s_tdata),
			.pat_byte  (pat_q[i*8 +: 8]),
			.next_byte (nxt[i]),
			.cand_byte (wp[i]),
			.eq        (eq[i])
		);
	end

	// match test and number of bytes leaving the window
	assign fillp = fill_q + 1'b1;
	assign match = !replaced_q && (fillp == plen_e) && (&eq);

	always_comb begin
		if (replaced_q) begin
			pc = CW'(1);
		end else if (fillp >= plen_e) begin
			pc = fillp - plen_e + 1'b1;
		end else begin
			pc = '0;
		end
		k = s_tlast ? fillp : pc;
		if (match) begin
			n = (rlen_e == '0) ? NW'(s_tlast) : NW'(rlen_e);
		end else begin
			n = NW'(k);
		end
	end

	// shift network feeding the window cells
	always_comb begin
		for (int x = 0; x < EXT; x++) begin
			wp_x[x] = '0;
		end
		for (int x = 0; x < PAT_CAP; x++) begin
			wp_x[x] = wp[x];
		end
		for (int i = 0; i < PAT_CAP; i++) begin
			nxt[i] = wp[i];
			for (int j = 0; j <= PAT_CAP; j++) begin
				if (k == CW'(j)) begin
					nxt[i] = wp_x[i + j];
				end
			end
		end
	end

	// results of the accepted byte, in order
	always_comb begin
		for (int j = 0; j < QD; j++) begin
			res[j] = '0;
		end
		for (int j = 0; j < MAXRES; j++) begin
			if (NW'(j) < n) begin
				res[j].run_last = (NW'(j) == NW'(n - 1'b1));
				res[j].line_end = res[j].run_last && s_tlast;
				if (match) begin
					if (rlen_e == '0) begin
						res[j].out_byte = '0;
						res[j].has_byte = 1'b0;
					end else begin
						res[j].out_byte = rep_q[j*8 +: 8];
						res[j].has_byte = 1'b1;
					end
				end else begin
					res[j].out_byte = wp_x[j];
					res[j].has_byte = 1'b1;
				end
			end
		end
	end

	// line state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= '0;
			replaced_q <= 1'b0;
		end else if (push) begin
			if (s_tlast || match) begin
				fill_q <= '0;
			end else begin
				fill_q <= fillp - k;
			end
			if (s_tlast) begin
				replaced_q <= 1'b0;
			end else if (match) begin
				replaced_q <= 1'b1;
			end
		end
	end

	// output queue: new words land right behind the words that stay
	assign base1 = (cnt_q - QCW'(pop)) != '0;

	for (genvar i = 0; i < QD; i++) begin : g_oq
		sfmr_pkg::res_t below;
		sfmr_pkg::res_t upper;

		assign oq_ctl[i].load       = push && !base1 && (32'(n) > i);
		assign oq_ctl[i].load_below = push && base1 && (i >= 1) && (32'(n) > i - 1);
		assign oq_ctl[i].shift      = pop;

		if (i == 0) begin : g_head
			assign below = '0;
		end else begin : g_body
			assign below = res[i-1];
		end

		if (i == QD - 1) begin : g_tail
			assign upper = '0;
		end else begin : g_mid
			assign upper = oq[i+1];
		end

		sfmr_out_cell u_cell (
			.clk       (clk),
			.ctl       (oq_ctl[i]),
			.res_here  (res[i]),
			.res_below (below),
			.from_next (upper),
			.word      (oq[i])
		);
	end

	// queue occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q - QCW'(pop) + (push ? QCW'(n) : QCW'(0));
		end
	end

	// output port
	assign m_tvalid   = cnt_q != '0;
	assign m_tdata    = oq[0].out_byte;
	assign m_tuser[0] = oq[0].has_byte;
	assign m_tuser[1] = oq[0].run_last;
	assign m_tlast    = oq[0].line_end;

	// checks
	`SFMR_ASSERT(a_queue_bound, cnt_q <= QCW'(QD), "output queue overfilled")
	`SFMR_ASSERT(a_push_room, !push || (32'(cnt_q) - 32'(pop) + 32'(n) <= QD), "burst does not fit")
	`SFMR_ASSERT(a_fill_bound, fill_q < CW'(PAT_CAP), "window holds a full pattern after a step")
	`SFMR_ASSERT(a_replaced_empty, !replaced_q || fill_q == '0, "window not empty after replacement")
	`SFMR_ASSERT_NEXT(a_line_clear, push && s_tlast, !replaced_q && fill_q == '0, "line state kept")

endmodule

### src/sfmr_win_cell.sv
// sfmr_win_cell.sv: one byte cell of the sliding match window
// depends on sfmr_pkg
module sfmr_win_cell (
	input  logic              clk,
	input  sfmr_pkg::win_ctl_t ctl,
	input  logic [7:0]        in_byte,
	input  logic [7:0]        pat_byte,
	input  logic [7:0]        next_byte,
	output logic [7:0]        cand_byte,
	output logic              eq
);

	logic [7:0] byte_q;

	// candidate byte: stored byte, or the incoming byte at the fill position
	assign cand_byte = ctl.use_store ? byte_q : in_byte;

	// compare against the pattern byte; inactive cells always agree
	assign eq = !ctl.active || (cand_byte == pat_byte);

	// take the byte handed over from the shift network
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			byte_q <= next_byte;
		end
	end

endmodule

### src/sfmr_out_cell.sv
// sfmr_out_cell.sv: one entry of the output queue, shifts toward the head
// depends on sfmr_pkg
module sfmr_out_cell (
	input  logic              clk,
	input  sfmr_pkg::oq_ctl_t ctl,
	input  sfmr_pkg::res_t    res_here,
	input  sfmr_pkg::res_t    res_below,
	input  sfmr_pkg::res_t    from_next,
	output sfmr_pkg::res_t    word
);

	sfmr_pkg::res_t word_q;

	assign word = word_q;

	// new results take priority, then a shift toward the head
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			word_q <= res_here;
		end else if (ctl.load_below) begin
			word_q <= res_below;
		end else if (ctl.shift) begin
			word_q <= from_next;
		end
	end

endmodule
